[hw/rtl/aes128_pkg.sv]
package aes128_pkg;

  localparam int unsigned ROUNDS_DEF = 10;
  localparam int unsigned BLK_W      = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned POLY_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_POLY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MIX_POLY = 3'd4;

  localparam logic [POLY_W-1:0] MIX_POLY_RST     = 32'h0301_0102;
  localparam logic [POLY_W-1:0] INV_MIX_POLY_RST = 32'h0B0D_090E;

  localparam logic [7:0] RCON [16] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
    8'h80, 8'h1b, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

[hw/rtl/aes128_key_sched.sv]
module aes128_key_sched #(
  parameter int unsigned RndW = 4
) (
  input  logic [aes128_pkg::BLK_W-1:0] rk_i,
  input  logic [RndW-1:0]              round_i,
  input  logic                         inverse_i,
  output logic [aes128_pkg::BLK_W-1:0] rk_o
);
  import aes128_pkg::*;

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] rc;
  logic [31:0] f0, f1, f2, f3;
  logic [31:0] b1, b2, b3, b0;

  assign {w0, w1, w2, w3} = rk_i;
  assign rc = {RCON[4'(round_i)], 24'h0};

  // forward step: key of round_i from key of round_i-1
  assign f0 = w0 ^ sub_word({w3[23:0], w3[31:24]}) ^ rc;
  assign f1 = w1 ^ f0;
  assign f2 = w2 ^ f1;
  assign f3 = w3 ^ f2;

  // backward step: key of round_i-1 from key of round_i
  assign b3 = w3 ^ w2;
  assign b2 = w2 ^ w1;
  assign b1 = w1 ^ w0;
  assign b0 = w0 ^ sub_word({b3[23:0], b3[31:24]}) ^ rc;

  assign rk_o = inverse_i ? {b0, b1, b2, b3} : {f0, f1, f2, f3};

endmodule

[hw/rtl/aes128_round.sv]
module aes128_round (
  input  logic [aes128_pkg::BLK_W-1:0]  state_i,
  input  logic [aes128_pkg::BLK_W-1:0]  rk_i,
  input  logic                          decrypt_i,
  input  logic                          last_i,
  input  logic [aes128_pkg::POLY_W-1:0] mix_poly_i,
  input  logic [aes128_pkg::POLY_W-1:0] inv_mix_poly_i,
  output logic [aes128_pkg::BLK_W-1:0]  state_o
);
  import aes128_pkg::*;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc = acc ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [BLK_W-1:0] shift_rows(input logic [BLK_W-1:0] s,
                                                  input logic inv);
    logic [BLK_W-1:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv)
          o[BLK_W-1-8*(4*c+r) -: 8] = s[BLK_W-1-8*(4*((c-r+4)%4)+r) -: 8];
        else
          o[BLK_W-1-8*(4*c+r) -: 8] = s[BLK_W-1-8*(4*((c+r)%4)+r) -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [BLK_W-1:0] mix_cols(input logic [BLK_W-1:0] s,
                                                input logic [POLY_W-1:0] p);
    logic [BLK_W-1:0] o;
    logic [7:0] d;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        d = 8'h00;
        for (int k = 0; k < 4; k++)
          d = d ^ gf_mul(p[8*k +: 8], s[BLK_W-1-8*(4*c+((j-k+4)%4)) -: 8]);
        o[BLK_W-1-8*(4*c+j) -: 8] = d;
      end
    end
    return o;
  endfunction

  logic [BLK_W-1:0] enc_sub, enc_shift, enc_mix, enc_out;
  logic [BLK_W-1:0] dec_shift, dec_sub, dec_key, dec_out;

  always_comb begin
    for (int n = 0; n < 16; n++) begin
      enc_sub[BLK_W-1-8*n -: 8] = SBOX[state_i[BLK_W-1-8*n -: 8]];
      dec_sub[BLK_W-1-8*n -: 8] = INV_SBOX[dec_shift[BLK_W-1-8*n -: 8]];
    end
  end

  assign enc_shift = shift_rows(enc_sub, 1'b0);
  assign enc_mix   = last_i ? enc_shift : mix_cols(enc_shift, mix_poly_i);
  assign enc_out   = enc_mix ^ rk_i;

  assign dec_shift = shift_rows(state_i, 1'b1);
  assign dec_key   = dec_sub ^ rk_i;
  assign dec_out   = last_i ? dec_key : mix_cols(dec_key, inv_mix_poly_i);

  assign state_o = decrypt_i ? dec_out : enc_out;

endmodule

[hw/rtl/aes128_block_cipher.sv]
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | block_high_i, block_low_i
// out     | out_valid_o| out_stall_i | result_high_o, result_low_o
// cfg     | cfg_we_i   | -           | cfg_idx_i, cfg_wdata_i
// Each block gets the key addition at accept, then one round per cycle through
// the shared round unit and key-schedule step, ten rounds, save for the stall below.
// After reset and after each key write the schedule runs forward through every
// round to find the last round key; no request is taken meanwhile.
// A finished result waits in the output register; the last round holds
// while that register is full and stalled.
module aes128_block_cipher #(
  parameter int unsigned ROUNDS = aes128_pkg::ROUNDS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [aes128_pkg::HALF_W-1:0]     block_high_i,
  input  logic [aes128_pkg::HALF_W-1:0]     block_low_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [aes128_pkg::HALF_W-1:0]     result_high_o,
  output logic [aes128_pkg::HALF_W-1:0]     result_low_o,
  input  logic                              cfg_we_i,
  input  logic [aes128_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aes128_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import aes128_pkg::*;

  localparam int unsigned RndW = $clog2(ROUNDS + 1);
  localparam logic [RndW-1:0] RND_FIRST = RndW'(1);
  localparam logic [RndW-1:0] RND_LAST  = RndW'(ROUNDS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXPAND = 2'd1;
  localparam logic [1:0] S_RUN    = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic [BLK_W-1:0]  st_q, st_d;
  logic [BLK_W-1:0]  rk_q, rk_d;
  logic [BLK_W-1:0]  last_key_q, last_key_d;
  logic              dec_q, dec_d;
  logic              dirty_q, dirty_d;
  logic [HALF_W-1:0] key_hi_q, key_lo_q;
  logic              mode_q;
  logic [POLY_W-1:0] mix_q, imix_q;
  logic              out_valid_q, out_valid_d;
  logic [BLK_W-1:0]  out_q, out_d;

  logic [BLK_W-1:0]  ks_rk;
  logic [BLK_W-1:0]  rnd_out;
  logic              last_rnd;
  logic              in_acc;
  logic              out_free;

  assign last_rnd = dec_q ? (rnd_q == RND_FIRST) : (rnd_q == RND_LAST);
  assign in_stall_o = !((state_q == S_IDLE) && !dirty_q);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  aes128_key_sched #(.RndW(RndW)) u_key_sched (
    .rk_i      (rk_q),
    .round_i   (rnd_q),
    .inverse_i ((state_q == S_RUN) && dec_q),
    .rk_o      (ks_rk)
  );

  aes128_round u_round (
    .state_i        (st_q),
    .rk_i           (ks_rk),
    .decrypt_i      (dec_q),
    .last_i         (last_rnd),
    .mix_poly_i     (mix_q),
    .inv_mix_poly_i (imix_q),
    .state_o        (rnd_out)
  );

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    st_d        = st_q;
    rk_d        = rk_q;
    last_key_d  = last_key_q;
    dec_d       = dec_q;
    dirty_d     = dirty_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (dirty_q) begin
          rk_d    = {key_hi_q, key_lo_q};
          rnd_d   = RND_FIRST;
          dirty_d = 1'b0;
          state_d = S_EXPAND;
        end else if (in_acc) begin
          dec_d   = mode_q;
          state_d = S_RUN;
          if (mode_q) begin
            st_d  = {block_high_i, block_low_i} ^ last_key_q;
            rk_d  = last_key_q;
            rnd_d = RND_LAST;
          end else begin
            st_d  = {block_high_i, block_low_i} ^ {key_hi_q, key_lo_q};
            rk_d  = {key_hi_q, key_lo_q};
            rnd_d = RND_FIRST;
          end
        end
      end
      S_EXPAND: begin
        rk_d = ks_rk;
        if (rnd_q == RND_LAST) begin
          last_key_d = ks_rk;
          state_d    = S_IDLE;
        end else begin
          rnd_d = rnd_q + RND_FIRST;
        end
      end
      S_RUN: begin
        if (!last_rnd) begin
          st_d  = rnd_out;
          rk_d  = ks_rk;
          rnd_d = dec_q ? rnd_q - RND_FIRST : rnd_q + RND_FIRST;
        end else if (out_free) begin
          out_d       = rnd_out;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_we_i && (cfg_idx_i == REG_KEY_HIGH || cfg_idx_i == REG_KEY_LOW)) begin
      dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= '0;
      dec_q       <= 1'b0;
      dirty_q     <= 1'b1;
      out_valid_q <= 1'b0;
      key_hi_q    <= '0;
      key_lo_q    <= '0;
      mode_q      <= 1'b0;
      mix_q       <= MIX_POLY_RST;
      imix_q      <= INV_MIX_POLY_RST;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      dec_q       <= dec_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_HIGH:     key_hi_q <= cfg_wdata_i;
          REG_KEY_LOW:      key_lo_q <= cfg_wdata_i;
          REG_DECRYPT_MODE: mode_q   <= cfg_wdata_i[0];
          REG_MIX_POLY:     mix_q    <= cfg_wdata_i[POLY_W-1:0];
          REG_INV_MIX_POLY: imix_q   <= cfg_wdata_i[POLY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q       <= st_d;
    rk_q       <= rk_d;
    last_key_q <= last_key_d;
    out_q      <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = out_q[BLK_W-1:HALF_W];
  assign result_low_o  = out_q[HALF_W-1:0];

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == S_IDLE) && !dirty_q)
    else $error("request taken while busy");

  a_accept_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RUN))
    else $error("accepted request did not start rounds");

  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (rnd_q >= RND_FIRST) && (rnd_q <= RND_LAST))
    else $error("round counter out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_q))
    else $error("held result overwritten");

endmodule
